// ===== src/tocg_pkg.sv =====
// tocg_pkg: shared types, constants and the 5x7 font for the text overlay.
// Used by every module of text_overlay_char_generator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tocg_pkg;

  // Default sizes handed to the top level
  localparam int MAX_CHARS_DEF   = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Field widths
  localparam int COORD_W = 12;
  localparam int FRAME_W = 13;
  localparam int SCALE_W = 5;
  localparam int LEN_W   = 7;
  localparam int LEVEL_W = 8;
  localparam int CODE_W  = 8;
  localparam int SLOT_W  = 6;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int ROWS    = 7;
  localparam int COLS    = 5;
  localparam int GLYPHS  = 43;

  // Register reset values
  localparam logic [COORD_W-1:0] RST_ORIGIN_X = 12'd36;
  localparam logic [COORD_W-1:0] RST_ORIGIN_Y = 12'd36;
  localparam logic [SCALE_W-1:0] RST_SCALE    = 5'd5;
  localparam logic [LEN_W-1:0]   RST_LENGTH   = 7'd0;
  localparam logic [FRAME_W-1:0] RST_WIDTH    = 13'd1280;
  localparam logic [FRAME_W-1:0] RST_HEIGHT   = 13'd720;
  localparam logic [LEVEL_W-1:0] RST_FG       = 8'd235;
  localparam logic [LEVEL_W-1:0] RST_BG       = 8'd24;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_SCALE    = 3'd2,
    REG_LENGTH   = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5,
    REG_FG       = 3'd6,
    REG_BG       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [SCALE_W-1:0] dot_scale;
    logic [LEN_W-1:0]   text_length;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
    logic [LEVEL_W-1:0] foreground_level;
    logic [LEVEL_W-1:0] background_level;
  } cfg_t;

  // Work classes decided by the front end
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,   // write a code into the text store
    OP_QUERY = 2'd1,   // pixel needs a character scan
    OP_BLANK = 2'd2    // pixel known uncovered up front
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [CODE_W-1:0]  code;
    logic [COORD_W-1:0] px;
    logic [ROWS-1:0]    rows;   // font rows whose band holds the pixel row
  } entry_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_SCAN = 2'd1,
    B_RES  = 2'd2
  } bstate_t;

  // Row 0 first; column 0 is bit 4 of each row
  typedef logic [0:ROWS-1][COLS-1:0] glyph_t;

  localparam glyph_t FONT [GLYPHS] = '{
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    '{5'h0e,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11},
    '{5'h1e,5'h11,5'h11,5'h1e,5'h11,5'h11,5'h1e},
    '{5'h0e,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0e},
    '{5'h1e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1e},
    '{5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h1f},
    '{5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h10},
    '{5'h0e,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0e},
    '{5'h11,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11},
    '{5'h0e,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0e},
    '{5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0c},
    '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
    '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1f},
    '{5'h11,5'h1b,5'h15,5'h15,5'h11,5'h11,5'h11},
    '{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
    '{5'h0e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e},
    '{5'h1e,5'h11,5'h11,5'h1e,5'h10,5'h10,5'h10},
    '{5'h0e,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0d},
    '{5'h1e,5'h11,5'h11,5'h1e,5'h14,5'h12,5'h11},
    '{5'h0f,5'h10,5'h10,5'h0e,5'h01,5'h01,5'h1e},
    '{5'h1f,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e},
    '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0a,5'h04},
    '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0a},
    '{5'h11,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h11},
    '{5'h11,5'h11,5'h0a,5'h04,5'h04,5'h04,5'h04},
    '{5'h1f,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1f},
    '{5'h0e,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0e},
    '{5'h04,5'h0c,5'h04,5'h04,5'h04,5'h04,5'h0e},
    '{5'h0e,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1f},
    '{5'h1e,5'h01,5'h01,5'h0e,5'h01,5'h01,5'h1e},
    '{5'h02,5'h06,5'h0a,5'h12,5'h1f,5'h02,5'h02},
    '{5'h1f,5'h10,5'h10,5'h1e,5'h01,5'h01,5'h1e},
    '{5'h0e,5'h10,5'h10,5'h1e,5'h11,5'h11,5'h0e},
    '{5'h1f,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
    '{5'h0e,5'h11,5'h11,5'h0e,5'h11,5'h11,5'h0e},
    '{5'h0e,5'h11,5'h11,5'h0f,5'h01,5'h01,5'h0e},
    '{5'h00,5'h00,5'h00,5'h1f,5'h00,5'h00,5'h00},
    '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0c,5'h0c},
    '{5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10},
    '{5'h00,5'h0c,5'h0c,5'h00,5'h0c,5'h0c,5'h00},
    '{5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02},
    '{5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08}
  };

  // Character code to glyph: a-z folded onto A-Z, unknown codes blank
  function automatic glyph_t glyph_of(input logic [CODE_W-1:0] code);
    logic [5:0] idx;
    idx = 6'd0;
    case (code) inside
      [8'h41:8'h5a]: idx = 6'(code - 8'h41) + 6'd1;
      [8'h61:8'h7a]: idx = 6'(code - 8'h61) + 6'd1;
      [8'h30:8'h39]: idx = 6'(code - 8'h30) + 6'd27;
      8'h2d:         idx = 6'd37;
      8'h2e:         idx = 6'd38;
      8'h2f:         idx = 6'd39;
      8'h3a:         idx = 6'd40;
      8'h28:         idx = 6'd41;
      8'h29:         idx = 6'd42;
      default:       idx = 6'd0;
    endcase
    return FONT[idx];
  endfunction

endpackage

`default_nettype wire

// ===== src/tocg_in_if.sv =====
// tocg_in_if: input channel of the text overlay (load and pixel query beats).
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface tocg_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [5:0]  char_slot;
  logic [7:0]  char_code;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;

  modport source (output valid, mode, char_slot, char_code, pixel_x, pixel_y,
                  input ready);
  modport sink (input valid, mode, char_slot, char_code, pixel_x, pixel_y,
                output ready);
endinterface

`default_nettype wire

// ===== src/tocg_out_if.sv =====
// tocg_out_if: result channel of the text overlay (luma and coverage beats).
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface tocg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       covered;

  modport source (output valid, luma, covered, input ready);
  modport sink (input valid, luma, covered, output ready);
endinterface

`default_nettype wire

// ===== src/tocg_front.sv =====
// tocg_front: accepts input beats, classifies them and finds the font rows
// whose band holds the pixel row. Depends on tocg_pkg and tocg_in_if.
`timescale 1ns / 1ps
`default_nettype none

module tocg_front (
  tocg_in_if.sink             in_bus,
  input  tocg_pkg::cfg_t      cfg,
  input  logic                full,
  output logic                push,
  output tocg_pkg::entry_t    push_data
);

  logic [tocg_pkg::ROWS-1:0] row_hit;
  logic                      in_frame;

  // Row bands: row r covers oy + r*s + 1 .. oy + r*s + 1 + s
  always_comb begin
    logic [tocg_pkg::FRAME_W-1:0] by;
    by = '0;
    for (int r = 0; r < tocg_pkg::ROWS; r++) begin
      by = tocg_pkg::FRAME_W'(cfg.origin_y)
         + tocg_pkg::FRAME_W'(r) * tocg_pkg::FRAME_W'(cfg.dot_scale)
         + tocg_pkg::FRAME_W'(1);
      row_hit[r] = (tocg_pkg::FRAME_W'(in_bus.pixel_y) >= by) &&
                   (tocg_pkg::FRAME_W'(in_bus.pixel_y) <=
                    by + tocg_pkg::FRAME_W'(cfg.dot_scale));
    end
  end

  assign in_frame = (tocg_pkg::FRAME_W'(in_bus.pixel_x) < cfg.frame_width) &&
                    (tocg_pkg::FRAME_W'(in_bus.pixel_y) < cfg.frame_height);

  // Classify the beat
  always_comb begin
    push_data.slot = in_bus.char_slot;
    push_data.code = in_bus.char_code;
    push_data.px   = in_bus.pixel_x;
    push_data.rows = row_hit;
    if (!in_bus.mode) begin
      push_data.op = tocg_pkg::OP_LOAD;
    end else if (in_frame && (|row_hit)) begin
      push_data.op = tocg_pkg::OP_QUERY;
    end else begin
      push_data.op = tocg_pkg::OP_BLANK;
    end
  end

  assign in_bus.ready = !full;
  assign push         = in_bus.valid && !full;

endmodule

`default_nettype wire

// ===== src/tocg_fifo.sv =====
// tocg_fifo: short register queue between the front end and the back end.
// Depends on tocg_pkg (entry_t).
`timescale 1ns / 1ps
`default_nettype none

module tocg_fifo #(
  parameter int DEPTH = tocg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tocg_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output tocg_pkg::entry_t head,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tocg_pkg::entry_t ent_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// ===== src/tocg_back.sv =====
// tocg_back: executes queued beats: text store writes and the per-character
// coverage scan, and holds the result register. Depends on tocg_pkg, tocg_out_if.
`timescale 1ns / 1ps
`default_nettype none

module tocg_back #(
  parameter int MAX_CHARS = tocg_pkg::MAX_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tocg_pkg::cfg_t   cfg,
  input  tocg_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  tocg_out_if.source       out_bus
);

  localparam int AW  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int KW  = $clog2(MAX_CHARS + 1);
  localparam int CXW = $clog2(4096 + (MAX_CHARS + 1) * 186 + 160);

  // Text store
  logic [tocg_pkg::CODE_W-1:0] mem [MAX_CHARS];
  logic [tocg_pkg::CODE_W-1:0] rdata_r;
  logic                        mem_we;
  logic [AW+5:0]               slot_w;

  tocg_pkg::bstate_t state_r, state_nxt;

  logic [tocg_pkg::COORD_W-1:0] q_px_r;
  logic [tocg_pkg::ROWS-1:0]    q_row_r;
  logic                         start;

  // Scan stage A: character counter and cell position
  logic           a_act_r, a_act_nxt;
  logic [KW-1:0]  k_r;
  logic [CXW-1:0] cx_r, nx_r;
  logic [CXW-1:0] cw;
  logic           a_stop, a_go;
  logic [tocg_pkg::COLS-1:0] col_hit;

  // Scan stage B: glyph lookup against the hit rows and columns
  logic                      b_val_r;
  logic [tocg_pkg::COLS-1:0] b_col_r;
  logic                      b_hit;
  tocg_pkg::glyph_t          glyph;

  logic res_cov_r, res_cov_nxt;
  logic out_valid_r, out_cov_r;
  logic [tocg_pkg::LEVEL_W-1:0] out_luma_r;
  logic out_free;

  assign cw       = CXW'(cfg.dot_scale) * CXW'(6);
  assign out_free = !out_valid_r || out_bus.ready;
  assign slot_w   = (AW + 6)'(head.slot);

  // Stage A stop: past the text or the store, past the frame, or cell starts at or right of pixel
  assign a_stop = (32'(k_r) >= 32'(cfg.text_length)) ||
                  (32'(k_r) >= MAX_CHARS) ||
                  ((k_r != '0) && (nx_r >= CXW'(cfg.frame_width))) ||
                  (CXW'(q_px_r) <= cx_r);
  assign a_go   = (state_r == tocg_pkg::B_SCAN) && a_act_r && !a_stop;

  // Column bands of character k, col c at cx + c*s + 1 .. + s
  always_comb begin
    logic [CXW-1:0] bx;
    bx = '0;
    for (int c = 0; c < tocg_pkg::COLS; c++) begin
      bx = cx_r + CXW'(c) * CXW'(cfg.dot_scale) + CXW'(1);
      col_hit[tocg_pkg::COLS-1-c] = (CXW'(q_px_r) >= bx) &&
                                    (CXW'(q_px_r) <= bx + CXW'(cfg.dot_scale));
    end
  end

  // Stage B coverage
  always_comb begin
    logic any;
    any   = 1'b0;
    glyph = tocg_pkg::glyph_of(rdata_r);
    for (int r = 0; r < tocg_pkg::ROWS; r++) begin
      any = any | (q_row_r[r] & (|(glyph[r] & b_col_r)));
    end
    b_hit = b_val_r && any;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    pop         = 1'b0;
    mem_we      = 1'b0;
    start       = 1'b0;
    res_cov_nxt = res_cov_r;
    a_act_nxt   = a_act_r && !a_stop;
    unique case (state_r)
      tocg_pkg::B_IDLE: begin
        a_act_nxt = 1'b0;
        if (!empty) begin
          pop = 1'b1;
          unique case (head.op)
            tocg_pkg::OP_LOAD: begin
              mem_we = (32'(head.slot) < MAX_CHARS);
            end
            tocg_pkg::OP_QUERY: begin
              start     = 1'b1;
              a_act_nxt = 1'b1;
              state_nxt = tocg_pkg::B_SCAN;
            end
            default: begin
              res_cov_nxt = 1'b0;
              state_nxt   = tocg_pkg::B_RES;
            end
          endcase
        end
      end
      tocg_pkg::B_SCAN: begin
        if (b_hit) begin
          res_cov_nxt = 1'b1;
          a_act_nxt   = 1'b0;
          state_nxt   = tocg_pkg::B_RES;
        end else if (!a_go && !b_val_r) begin
          res_cov_nxt = 1'b0;
          a_act_nxt   = 1'b0;
          state_nxt   = tocg_pkg::B_RES;
        end
      end
      tocg_pkg::B_RES: begin
        a_act_nxt = 1'b0;
        if (out_free) begin
          state_nxt = tocg_pkg::B_IDLE;
        end
      end
      default: begin
        a_act_nxt = 1'b0;
        state_nxt = tocg_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tocg_pkg::B_IDLE;
      a_act_r <= 1'b0;
      b_val_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_act_r <= a_act_nxt;
      b_val_r <= a_go;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_w[AW-1:0]] <= head.code;
    end
    if (a_go) begin
      rdata_r <= mem[k_r[AW-1:0]];
    end
  end

  // Query and scan datapath
  always_ff @(posedge clk) begin
    res_cov_r <= res_cov_nxt;
    if (start) begin
      q_px_r  <= head.px;
      q_row_r <= head.rows;
      k_r     <= '0;
      cx_r    <= CXW'(cfg.origin_x);
      nx_r    <= CXW'(cfg.origin_x) + cw;
    end else if (a_go) begin
      k_r  <= k_r + KW'(1);
      cx_r <= cx_r + cw;
      nx_r <= nx_r + cw;
    end
    if (a_go) begin
      b_col_r <= col_hit;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == tocg_pkg::B_RES && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tocg_pkg::B_RES && out_free) begin
      out_cov_r  <= res_cov_r;
      out_luma_r <= res_cov_r ? cfg.foreground_level : cfg.background_level;
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.luma    = out_luma_r;
  assign out_bus.covered = out_cov_r;

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    b_val_r |-> $past(state_r == tocg_pkg::B_SCAN))
    else $error("glyph stage loaded outside a scan");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tocg_pkg::B_RES))
    else $error("result raised without a finished query");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    a_act_r |-> (32'(k_r) <= MAX_CHARS))
    else $error("character counter ran past the store");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == tocg_pkg::B_IDLE))
    else $error("queue popped while a query is in progress");

endmodule

`default_nettype wire

// ===== src/text_overlay_char_generator.sv =====
// Single-line text overlay with a built-in 5x7 font (A-Z, 0-9, - . / : ( )).
//
// in_bus (valid/ready): mode 0 writes char_code into text slot char_slot;
// mode 1 asks for the luma at (pixel_x, pixel_y). Each query beat gives one
// beat on out_bus (luma, covered); load beats give none. cfg_we/cfg_index/
// cfg_data write the eight registers; write them only while the block is idle.
//
// A front end classifies beats into a short queue; the back end runs them in
// order. A load is written to the text store as the back end takes it. A pixel
// outside the frame or outside every font row band skips the scan and goes
// straight to the result register. Any other pixel is scanned one character
// per cycle (one text store read a cycle) from the first character until a
// cell that starts at or right of the pixel, the end of the drawn text, the
// frame or the store, or a hit. At most MAX_CHARS characters are checked.
// While out_bus is stalled the result is held and the queue keeps accepting
// until full. Reset restores the register defaults and empties the queue;
// the text store holds no reset value and must be written before use.
// Depends on tocg_pkg, tocg_in_if, tocg_out_if, tocg_front, tocg_fifo, tocg_back.
`timescale 1ns / 1ps
`default_nettype none

module text_overlay_char_generator #(
  parameter int MAX_CHARS   = tocg_pkg::MAX_CHARS_DEF,
  parameter int QUEUE_DEPTH = tocg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tocg_in_if.sink                           in_bus,
  tocg_out_if.source                        out_bus,
  input  logic                              cfg_we,
  input  logic [tocg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tocg_pkg::CFG_W-1:0]        cfg_data
);

  tocg_pkg::cfg_t   cfg_r;
  tocg_pkg::entry_t push_data, head;
  logic             push, full, pop, empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x         <= tocg_pkg::RST_ORIGIN_X;
      cfg_r.origin_y         <= tocg_pkg::RST_ORIGIN_Y;
      cfg_r.dot_scale        <= tocg_pkg::RST_SCALE;
      cfg_r.text_length      <= tocg_pkg::RST_LENGTH;
      cfg_r.frame_width      <= tocg_pkg::RST_WIDTH;
      cfg_r.frame_height     <= tocg_pkg::RST_HEIGHT;
      cfg_r.foreground_level <= tocg_pkg::RST_FG;
      cfg_r.background_level <= tocg_pkg::RST_BG;
    end else if (cfg_we) begin
      unique case (tocg_pkg::cfg_reg_t'(cfg_index))
        tocg_pkg::REG_ORIGIN_X: cfg_r.origin_x    <= cfg_data[tocg_pkg::COORD_W-1:0];
        tocg_pkg::REG_ORIGIN_Y: cfg_r.origin_y    <= cfg_data[tocg_pkg::COORD_W-1:0];
        tocg_pkg::REG_SCALE:    cfg_r.dot_scale   <= cfg_data[tocg_pkg::SCALE_W-1:0];
        tocg_pkg::REG_LENGTH:   cfg_r.text_length <= cfg_data[tocg_pkg::LEN_W-1:0];
        tocg_pkg::REG_WIDTH:    cfg_r.frame_width <= cfg_data;
        tocg_pkg::REG_HEIGHT:   cfg_r.frame_height <= cfg_data;
        tocg_pkg::REG_FG: cfg_r.foreground_level <= cfg_data[tocg_pkg::LEVEL_W-1:0];
        tocg_pkg::REG_BG: cfg_r.background_level <= cfg_data[tocg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  tocg_front u_front (
    .in_bus    (in_bus),
    .cfg       (cfg_r),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  tocg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  tocg_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire
